// ===== rtl/core/i2cm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and status codes shared by the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   typedef enum logic [1:0] {
      KIND_LOAD    = 2'd0,
      KIND_START   = 2'd1,
      KIND_STATUS  = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CSR_WRITE_ADDR = 2'd0,
      CSR_READ_ADDR  = 2'd1,
      CSR_WRITE_LEN  = 2'd2,
      CSR_READ_LEN   = 2'd3
   } csr_index_type;

   // controller status codes
   localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
   localparam logic [7:0] ST_START       = 8'h08;
   localparam logic [7:0] ST_RESTART     = 8'h10;
   localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
   localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
   localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST    = 8'h38;
   localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
   localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
   localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_R_NACK = 8'h58;
   localparam logic [7:0] ST_NO_INFO     = 8'hF8;

   typedef struct packed {
      logic [7:0] write_addr;
      logic [7:0] read_addr;
      logic [5:0] write_len;
      logic [5:0] read_len;
   } cfg_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       set_start;
      logic       clear_start;
      logic       set_stop;
      logic       ack_enable;
      logic       ack_disable;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [4:0] rx_index;
      logic       done_res;
      logic       failed;
   } rsp_type;

endpackage

// ===== rtl/core/i2c_master_transfer_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// A response is formed when its request is accepted and is registered in the
// output buffer. One request per cycle while that buffer is not full; the next
// write byte is prefetched from the buffer RAM, so its read adds no stall.
// Reset clears positions, flags, config registers and the response buffer;
// the write buffer RAM is not cleared and holds no valid data until loaded.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_core #(
   parameter int BUF_DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_status_code,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_load_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_send_valid,
   output logic [7:0] rsp_send_byte,
   output logic       rsp_set_start,
   output logic       rsp_clear_start,
   output logic       rsp_set_stop,
   output logic       rsp_ack_enable,
   output logic       rsp_ack_disable,
   output logic       rsp_rx_valid,
   output logic [7:0] rsp_rx_byte,
   output logic [4:0] rsp_rx_index,
   output logic       rsp_done_res,
   output logic       rsp_failed,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

   i2cm_pkg::cfg_type cfg_ff, cfg_in;
   i2cm_pkg::rsp_type rsp_new, rsp_out;
   logic              req_fire, buf_full;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   assign csr_ready = 1'b1;
   assign req_ready = !buf_full;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (i2cm_pkg::csr_index_type'(csr_index))
            i2cm_pkg::CSR_WRITE_ADDR: cfg_in.write_addr = csr_data;
            i2cm_pkg::CSR_READ_ADDR:  cfg_in.read_addr  = csr_data;
            i2cm_pkg::CSR_WRITE_LEN:  cfg_in.write_len  = csr_data[5:0];
            i2cm_pkg::CSR_READ_LEN:   cfg_in.read_len   = csr_data[5:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   i2cm_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_tx_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   i2cm_ctrl #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_fire        (req_fire),
      .req_kind        (req_kind),
      .req_status_code (req_status_code),
      .req_data_byte   (req_data_byte),
      .req_load_index  (req_load_index),
      .ram_we          (ram_we),
      .ram_waddr       (ram_waddr),
      .ram_wdata       (ram_wdata),
      .ram_raddr       (ram_raddr),
      .ram_rdata       (ram_rdata),
      .rsp             (rsp_new)
   );

   i2cm_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (req_fire),
      .push_data (rsp_new),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_out)
   );

   assign rsp_send_valid  = rsp_out.send_valid;
   assign rsp_send_byte   = rsp_out.send_byte;
   assign rsp_set_start   = rsp_out.set_start;
   assign rsp_clear_start = rsp_out.clear_start;
   assign rsp_set_stop    = rsp_out.set_stop;
   assign rsp_ack_enable  = rsp_out.ack_enable;
   assign rsp_ack_disable = rsp_out.ack_disable;
   assign rsp_rx_valid    = rsp_out.rx_valid;
   assign rsp_rx_byte     = rsp_out.rx_byte;
   assign rsp_rx_index    = rsp_out.rx_index;
   assign rsp_done_res    = rsp_out.done_res;
   assign rsp_failed      = rsp_out.failed;

endmodule

// ===== rtl/core/i2cm_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_ram
// Generic single-write, single-read RAM with registered read (read-old).
// ----------------------------------------------------------------------------
module i2cm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/i2cm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_ctrl
// Transfer state and status decode; prefetches the next write byte from RAM.
// ----------------------------------------------------------------------------
module i2cm_ctrl #(
   parameter int BUF_DEPTH = 32
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  i2cm_pkg::cfg_type                                cfg,
   input  logic                                             req_fire,
   input  logic [1:0]                                       req_kind,
   input  logic [7:0]                                       req_status_code,
   input  logic [7:0]                                       req_data_byte,
   input  logic [4:0]                                       req_load_index,
   output logic                                             ram_we,
   output logic [((BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1)-1:0] ram_waddr,
   output logic [7:0]                                       ram_wdata,
   output logic [((BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1)-1:0] ram_raddr,
   input  logic [7:0]                                       ram_rdata,
   output i2cm_pkg::rsp_type                                rsp
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam logic [8:0] DEPTH9 = 9'(BUF_DEPTH);

   logic [5:0] tx_pos_ff, tx_pos_in;
   logic [5:0] rx_pos_ff, rx_pos_in;
   logic       started_ff, started_in;
   logic       complete_ff, complete_in;
   logic       failed_ff, failed_in;
   logic       fwd_valid_ff, fwd_valid_in;
   logic [7:0] fwd_data_ff;

   logic [8:0]         wlen9, rlen9;
   logic [5:0]         wlen, rlen;
   logic [7:0]         tx_byte;
   logic [6:0]         rx_next7;
   i2cm_pkg::kind_type kind;

   assign kind  = i2cm_pkg::kind_type'(req_kind);
   assign wlen9 = (9'(cfg.write_len) > DEPTH9) ? DEPTH9 : 9'(cfg.write_len);
   assign rlen9 = (9'(cfg.read_len) > DEPTH9) ? DEPTH9 : 9'(cfg.read_len);
   assign wlen  = wlen9[5:0];
   assign rlen  = rlen9[5:0];
   assign tx_byte = fwd_valid_ff ? fwd_data_ff : ram_rdata;

   always_comb begin
      tx_pos_in   = tx_pos_ff;
      rx_pos_in   = rx_pos_ff;
      started_in  = started_ff;
      complete_in = complete_ff;
      failed_in   = failed_ff;
      rx_next7    = '0;
      rsp         = '0;
      if (req_fire) begin
         unique case (kind)
            i2cm_pkg::KIND_LOAD: begin
            end
            i2cm_pkg::KIND_START: begin
               started_in    = 1'b0;
               complete_in   = 1'b0;
               failed_in     = 1'b0;
               tx_pos_in     = '0;
               rx_pos_in     = '0;
               rsp.set_start = 1'b1;
            end
            i2cm_pkg::KIND_STATUS: begin
               unique case (req_status_code) inside
                  i2cm_pkg::ST_START: begin
                     started_in      = 1'b1;
                     rsp.send_valid  = 1'b1;
                     rsp.send_byte   = cfg.write_addr;
                     rsp.clear_start = 1'b1;
                  end
                  i2cm_pkg::ST_RESTART: begin
                     if (cfg.read_addr != 8'd0) begin
                        rsp.send_valid = 1'b1;
                        rsp.send_byte  = cfg.read_addr;
                     end else begin
                        started_in   = 1'b0;
                        complete_in  = 1'b1;
                        failed_in    = 1'b1;
                        rsp.set_stop = 1'b1;
                     end
                     rsp.clear_start = 1'b1;
                  end
                  i2cm_pkg::ST_ADDR_W_ACK, i2cm_pkg::ST_ADDR_W_NACK,
                  i2cm_pkg::ST_DATA_W_ACK, i2cm_pkg::ST_DATA_W_NACK: begin
                     if (tx_pos_ff < wlen) begin
                        rsp.send_valid = 1'b1;
                        rsp.send_byte  = tx_byte;
                        tx_pos_in      = tx_pos_ff + 6'd1;
                     end else if (rlen != 6'd0) begin
                        rsp.set_start = 1'b1;
                     end else begin
                        complete_in  = 1'b1;
                        rsp.set_stop = 1'b1;
                     end
                  end
                  i2cm_pkg::ST_ADDR_R_ACK: begin
                     if (rlen > 6'd1) begin
                        rsp.ack_enable = 1'b1;
                     end else begin
                        rsp.ack_disable = 1'b1;
                     end
                  end
                  i2cm_pkg::ST_DATA_R_ACK, i2cm_pkg::ST_DATA_R_NACK: begin
                     if (rx_pos_ff < rlen) begin
                        rsp.rx_valid = 1'b1;
                        rsp.rx_byte  = req_data_byte;
                        rsp.rx_index = rx_pos_ff[4:0];
                        rx_pos_in    = rx_pos_ff + 6'd1;
                     end
                     rx_next7 = 7'(rx_pos_in) + 7'd1;
                     if (rx_next7 >= 7'(rlen)) begin
                        rsp.ack_disable = 1'b1;
                        if (rx_pos_in >= rlen) begin
                           complete_in  = 1'b1;
                           rsp.set_stop = 1'b1;
                        end
                     end
                  end
                  i2cm_pkg::ST_ARB_LOST: begin
                     complete_in = 1'b1;
                     failed_in   = 1'b1;
                  end
                  i2cm_pkg::ST_NO_INFO: begin
                  end
                  default: begin
                     // bus error, read address NACK and unknown codes
                     complete_in  = 1'b1;
                     failed_in    = 1'b1;
                     rsp.set_stop = 1'b1;
                  end
               endcase
            end
            i2cm_pkg::KIND_TIMEOUT: begin
               if (started_ff && !complete_ff) begin
                  complete_in = 1'b1;
                  failed_in   = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      rsp.done_res = complete_in || !started_in;
      rsp.failed   = failed_in;
   end

   // RAM ports: read tracks the next write position, or entry 0 past the buffer end
   assign ram_we    = req_fire && (kind == i2cm_pkg::KIND_LOAD) &&
                      (9'(req_load_index) < DEPTH9);
   assign ram_waddr = AW'(req_load_index);
   assign ram_wdata = req_data_byte;
   assign ram_raddr = (9'(tx_pos_in) < DEPTH9) ? AW'(tx_pos_in) : '0;

   // same-entry write in the read cycle: forward the new byte
   assign fwd_valid_in = ram_we && (9'(req_load_index) == 9'(tx_pos_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_pos_ff    <= '0;
         rx_pos_ff    <= '0;
         started_ff   <= 1'b0;
         complete_ff  <= 1'b0;
         failed_ff    <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         tx_pos_ff    <= tx_pos_in;
         rx_pos_ff    <= rx_pos_in;
         started_ff   <= started_in;
         complete_ff  <= complete_in;
         failed_ff    <= failed_in;
         fwd_valid_ff <= fwd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= req_data_byte;
   end

   a_tx_pos_bound: assert property (@(posedge clock) disable iff (reset)
      9'(tx_pos_ff) <= DEPTH9)
      else $error("write position beyond buffer");

   a_fail_completes: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> complete_ff)
      else $error("failed transfer not complete");

   a_fwd_from_write: assert property (@(posedge clock) disable iff (reset)
      fwd_valid_in |=> fwd_valid_ff && (fwd_data_ff == $past(req_data_byte)))
      else $error("forwarded byte lost");

endmodule

// ===== rtl/core/i2cm_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_out_buf
// Two-entry response buffer: output register plus skid stage.
// ----------------------------------------------------------------------------
module i2cm_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  i2cm_pkg::rsp_type push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_ready,
   output i2cm_pkg::rsp_type out_data
);

   logic              out_valid_ff, skid_valid_ff;
   i2cm_pkg::rsp_type out_data_ff, skid_data_ff;
   logic              pop;

   assign pop       = out_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : push_data;
      end else if (push) begin
         skid_data_ff <= push_data;
      end
   end

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a request while output is empty");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("push into full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> out_valid_ff && !skid_valid_ff)
      else $error("skid entry not advanced");

endmodule
